// File: rtl/pgc_pkg.sv
// ----------------------------------------------------------------------------
// pgc_pkg
// Widths, register indexes and payload types shared by the gamma pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pgc_pkg;

	localparam int PIXEL_BITS  = 16;
	localparam int MAX_GAMMA   = 4;
	localparam int GAMMA_W     = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int NUM_W       = 4 * PIXEL_BITS;
	localparam int DEN_W       = 3 * PIXEL_BITS;
	localparam int DIV_STAGES  = PIXEL_BITS;

	localparam logic [PIXEL_BITS-1:0] MAX_GRAY_RST = PIXEL_BITS'(255);
	localparam logic [GAMMA_W-1:0]    GAMMA_RST    = GAMMA_W'(2);
	localparam logic [GAMMA_W-1:0]    GAMMA_SAT    = GAMMA_W'(MAX_GAMMA);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_GRAY = 2'd0,
		REG_GAMMA    = 2'd1
	} cfg_reg_t;

	// one divider stage: partial remainder, divisor and quotient so far
	typedef struct packed {
		logic [NUM_W-1:0]      rem;
		logic [DEN_W-1:0]      den;
		logic [PIXEL_BITS-1:0] quo;
	} div_t;

endpackage

`default_nettype wire

// File: rtl/pixel_gamma_correction_unit.sv
// ----------------------------------------------------------------------------
// Pixel gamma correction unit
// Streams one gray pixel per cycle when not stalled and returns max *
// (pixel/max)^gamma as the exact integer floor(p^g / max^(g-1)), p being
// the pixel clamped to max. Stages: clamp, squares, cube and fourth power,
// numerator/divisor select, then a 16-stage restoring divider resolving
// one quotient bit per stage. The whole pipeline advances together; while
// out_valid is high, out_stall holds every stage and is returned as
// in_stall. Configuration writes are always ready and take effect on the
// next pixel accepted; write them only while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_gamma_correction_unit
	import pgc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [PIXEL_BITS-1:0] pixel_in,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [PIXEL_BITS-1:0]      pixel_out,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [PIXEL_BITS-1:0] cfg_data
);

	logic [PIXEL_BITS-1:0] max_gray_q;
	logic [GAMMA_W-1:0]    gamma_q;
	logic                  adv;

	assign cfg_ready = 1'b1;
	assign adv       = !(out_valid && out_stall);
	assign in_stall  = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gray_q <= MAX_GRAY_RST;
			gamma_q    <= GAMMA_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MAX_GRAY: max_gray_q <= cfg_data;
				REG_GAMMA:    gamma_q    <= cfg_data[GAMMA_W-1:0];
				default:      ;
			endcase
		end
	end

	// stage 1: clamp and saturate
	logic                  v_s1, zero_s1;
	logic [PIXEL_BITS-1:0] p_s1, m_s1;
	logic [GAMMA_W-1:0]    g_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1    <= (pixel_in > max_gray_q) ? max_gray_q : pixel_in;
			m_s1    <= max_gray_q;
			zero_s1 <= (max_gray_q == '0);
			g_s1    <= (gamma_q > GAMMA_SAT) ? GAMMA_SAT : gamma_q;
		end
	end

	// stage 2: squares
	logic                    v_s2, zero_s2;
	logic [PIXEL_BITS-1:0]   p_s2, m_s2;
	logic [GAMMA_W-1:0]      g_s2;
	logic [2*PIXEL_BITS-1:0] p2_s2, m2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2    <= p_s1;
			m_s2    <= m_s1;
			zero_s2 <= zero_s1;
			g_s2    <= g_s1;
			p2_s2   <= (2*PIXEL_BITS)'(p_s1) * (2*PIXEL_BITS)'(p_s1);
			m2_s2   <= (2*PIXEL_BITS)'(m_s1) * (2*PIXEL_BITS)'(m_s1);
		end
	end

	// stage 3: cube and fourth power
	logic                    v_s3, zero_s3;
	logic [PIXEL_BITS-1:0]   p_s3, m_s3;
	logic [GAMMA_W-1:0]      g_s3;
	logic [2*PIXEL_BITS-1:0] p2_s3, m2_s3;
	logic [DEN_W-1:0]        p3_s3, m3_s3;
	logic [NUM_W-1:0]        p4_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s3    <= p_s2;
			m_s3    <= m_s2;
			zero_s3 <= zero_s2;
			g_s3    <= g_s2;
			p2_s3   <= p2_s2;
			m2_s3   <= m2_s2;
			p3_s3   <= DEN_W'(p2_s2) * DEN_W'(p_s2);
			m3_s3   <= DEN_W'(m2_s2) * DEN_W'(m_s2);
			p4_s3   <= NUM_W'(p2_s2) * NUM_W'(p2_s2);
		end
	end

	// stage 4: pick numerator and divisor for the exponent
	logic             v_s4;
	logic [NUM_W-1:0] num_s4;
	logic [DEN_W-1:0] den_s4;
	logic [NUM_W-1:0] num_c;
	logic [DEN_W-1:0] den_c;

	always_comb begin
		unique case (g_s3)
			GAMMA_W'(0): begin
				num_c = NUM_W'(m_s3);
				den_c = DEN_W'(1);
			end
			GAMMA_W'(1): begin
				num_c = NUM_W'(p_s3);
				den_c = DEN_W'(1);
			end
			GAMMA_W'(2): begin
				num_c = NUM_W'(p2_s3);
				den_c = DEN_W'(m_s3);
			end
			GAMMA_W'(3): begin
				num_c = NUM_W'(p3_s3);
				den_c = DEN_W'(m2_s3);
			end
			default: begin
				num_c = p4_s3;
				den_c = m3_s3;
			end
		endcase
		// zero full scale: force 0/1 to keep the divider defined
		if (zero_s3) begin
			num_c = '0;
			den_c = DEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s4 <= num_c;
			den_s4 <= den_c;
		end
	end

	// stages 5..20: restoring divider, most significant quotient bit first
	div_t div_s [DIV_STAGES];
	logic [DIV_STAGES-1:0] div_v_s;

	for (genvar gi = 0; gi < DIV_STAGES; gi++) begin : g_div
		localparam int B = DIV_STAGES - 1 - gi;
		div_t             src;
		logic             src_v;
		logic [NUM_W-1:0] trial;

		if (gi == 0) begin : g_first
			assign src   = '{rem: num_s4, den: den_s4, quo: '0};
			assign src_v = v_s4;
		end else begin : g_next
			assign src   = div_s[gi-1];
			assign src_v = div_v_s[gi-1];
		end

		assign trial = NUM_W'(src.den) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) div_v_s[gi] <= 1'b0;
			else if (adv) div_v_s[gi] <= src_v;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[gi].den <= src.den;
				if (src.rem >= trial) begin
					div_s[gi].rem    <= src.rem - trial;
					div_s[gi].quo    <= src.quo | (PIXEL_BITS'(1) << B);
				end else begin
					div_s[gi].rem    <= src.rem;
					div_s[gi].quo    <= src.quo;
				end
			end
		end
	end

	assign out_valid = div_v_s[DIV_STAGES-1];
	assign pixel_out = div_s[DIV_STAGES-1].quo;

	// result never exceeds full scale
	a_out_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pixel_out <= max_gray_q))
		else $error("pixel_out above max_gray");

	// quotient fits in a pixel: remainder below divisor shifted by pixel width
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> ((num_s4 >> PIXEL_BITS) < NUM_W'(den_s4)))
		else $error("divider input out of range");

	// a stalled result stays on the output and the divider valid bits hold
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(pixel_out)
			&& $stable(div_v_s)))
		else $error("pipeline moved while stalled");

	a_cfg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && den_s4 == '0) |-> 1'b0)
		else $error("divider fed a zero divisor");

endmodule

`default_nettype wire
